FILE: src/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
	localparam int unsigned GRP_MAX  = 3;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_HEX0  = 3'd2,
		MODE_HEX1  = 3'd3,
		MODE_HEX2  = 3'd4,
		MODE_HEX3  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_CLOSED    = 3'd1,
		ST_UNCLOSED  = 3'd2,
		ST_BAD_ESC   = 3'd3,
		ST_SHORT_UNI = 3'd4,
		ST_BAD_HEX   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		status_t    status;
		logic       last;
	} result_t;

	// Up to three results caused by one input item, in order from index 0.
	typedef struct packed {
		logic [1:0]               n;
		result_t [GRP_MAX-1:0]    res;
	} group_t;

	// Returns {valid, value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic result_t mk_term(input status_t st);
		result_t r;
		r.out_byte = '0;
		r.has_byte = 1'b0;
		r.status   = st;
		r.last     = 1'b1;
		return r;
	endfunction

	function automatic result_t mk_byte(input logic [7:0] b, input logic fin);
		result_t r;
		r.out_byte = b;
		r.has_byte = 1'b1;
		r.status   = ST_BUSY;
		r.last     = fin;
		return r;
	endfunction

endpackage

FILE: src/jsu_decode.sv
// Escape decoder: mode and code point registers plus per-item result group.
module jsu_decode import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output group_t     grp
);

	mode_t       mode_q, mode_d, mode;
	logic [15:0] hex_q, hex_d, hv;
	logic [4:0]  hd;

	assign mode = (mode_q > MODE_HEX3) ? MODE_PLAIN : mode_q;
	assign hd   = hex_digit(data_byte);
	assign hv   = {hex_q[11:0], hd[3:0]};

	// next state
	always_comb begin
		mode_d = mode;
		hex_d  = hex_q;
		if (kind) begin
			mode_d = MODE_PLAIN;
			hex_d  = '0;
		end else begin
			case (mode)
				MODE_PLAIN: begin
					if (data_byte == CH_QUOTE || data_byte == CH_LF) begin
						hex_d = '0;
					end else if (data_byte == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end
				end
				MODE_ESC: begin
					mode_d = MODE_PLAIN;
					if (data_byte == CH_U) begin
						mode_d = MODE_HEX0;
						hex_d  = '0;
					end else if (!(data_byte == CH_QUOTE || data_byte == CH_BSLASH ||
							data_byte == CH_SLASH || data_byte == CH_B ||
							data_byte == CH_F || data_byte == CH_N ||
							data_byte == CH_R || data_byte == CH_T)) begin
						hex_d = '0;
					end
				end
				MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
					if (!hd[4] || mode == MODE_HEX3) begin
						mode_d = MODE_PLAIN;
						hex_d  = '0;
					end else begin
						hex_d = hv;
						case (mode)
							MODE_HEX0: mode_d = MODE_HEX1;
							MODE_HEX1: mode_d = MODE_HEX2;
							default:   mode_d = MODE_HEX3;
						endcase
					end
				end
				default: begin
					mode_d = MODE_PLAIN;
				end
			endcase
		end
	end

	// results
	always_comb begin
		grp = '0;
		if (kind) begin
			grp.n      = 2'd1;
			grp.res[0] = mk_term((mode >= MODE_HEX0) ? ST_SHORT_UNI : ST_UNCLOSED);
		end else begin
			case (mode)
				MODE_PLAIN: begin
					if (data_byte == CH_QUOTE) begin
						grp.n      = 2'd1;
						grp.res[0] = mk_term(ST_CLOSED);
					end else if (data_byte == CH_LF) begin
						grp.n      = 2'd1;
						grp.res[0] = mk_term(ST_UNCLOSED);
					end else if (data_byte != CH_BSLASH) begin
						grp.n      = 2'd1;
						grp.res[0] = mk_byte(data_byte, 1'b1);
					end
				end
				MODE_ESC: begin
					grp.n = 2'd1;
					case (data_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: grp.res[0] = mk_byte(data_byte, 1'b1);
						CH_B:    grp.res[0] = mk_byte(8'h08, 1'b1);
						CH_F:    grp.res[0] = mk_byte(8'h0C, 1'b1);
						CH_N:    grp.res[0] = mk_byte(8'h0A, 1'b1);
						CH_R:    grp.res[0] = mk_byte(8'h0D, 1'b1);
						CH_T:    grp.res[0] = mk_byte(8'h09, 1'b1);
						CH_U:    grp.n      = 2'd0;
						default: grp.res[0] = mk_term(ST_BAD_ESC);
					endcase
				end
				MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
					if (!hd[4]) begin
						grp.n      = 2'd1;
						grp.res[0] = mk_term(ST_BAD_HEX);
					end else if (mode == MODE_HEX3) begin
						if (hv[15:7] == '0) begin
							grp.n      = 2'd1;
							grp.res[0] = mk_byte({1'b0, hv[6:0]}, 1'b1);
						end else if (hv[15:11] == '0) begin
							grp.n      = 2'd2;
							grp.res[0] = mk_byte({3'b110, hv[10:6]}, 1'b0);
							grp.res[1] = mk_byte({2'b10, hv[5:0]}, 1'b1);
						end else begin
							grp.n      = 2'd3;
							grp.res[0] = mk_byte({4'b1110, hv[15:12]}, 1'b0);
							grp.res[1] = mk_byte({2'b10, hv[11:6]}, 1'b0);
							grp.res[2] = mk_byte({2'b10, hv[5:0]}, 1'b1);
						end
					end
				end
				default: begin
					grp.n = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			hex_q  <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
		end
	end

endmodule

FILE: src/jsu_outq.sv
// Result queue: takes a group of up to three results, hands out one per cycle while pop is high.
module jsu_outq import jsu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  group_t            grp,
	input  logic              pop,
	output logic [QCNT_W-1:0] count,
	output result_t           head
);

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   rd_q, wr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [1:0]          nput;

	assign nput  = push ? grp.n : 2'd0;
	assign count = cnt_q;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < GRP_MAX; i++) begin
			if (2'(i) < nput) begin
				mem_q[QPTR_W'(wr_q + QPTR_W'(i))] <= grp.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= QPTR_W'(wr_q + QPTR_W'(nput));
			if (pop) begin
				rd_q <= QPTR_W'(rd_q + 1'b1);
			end
			cnt_q <= QCNT_W'(cnt_q + QCNT_W'(nput) - QCNT_W'(pop));
		end
	end

endmodule

FILE: src/json_string_unescape.sv
// Top level of the JSON string unescaper.
//
// Takes a JSON string body one byte per transfer (starting after the opening
// quote) and returns the decoded UTF-8 bytes, one result per transfer. Each
// input transfer lands in an input register; the decoder then turns it,
// combinationally, into a group of zero to three results that is written into a
// four-entry result queue, from which results leave one per cycle while the
// result channel does not stall. The first result of an input byte passes
// through the input register and the result queue before it shows at the output.
// Plain text and simple escapes run at one byte per cycle when neither channel
// stalls; a \uXXXX escape yields up to three bytes from its last hex digit, so
// for that item the input side holds until the queue has drained room for the
// whole group. The input register advances only when the queue has space for
// the full group of the item it holds, so an item's results are never split.
module json_string_unescape import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// input byte channel
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic [2:0] status,
	output logic       last
);

	logic              valid_s1;
	logic              kind_s1;
	logic [7:0]        data_s1;
	group_t            grp;
	logic              advance;
	logic              pop;
	logic [QCNT_W-1:0] qcount;
	result_t           head;

	// Advance the held item only when the queue can take its whole group.
	assign advance    = valid_s1 && (QCNT_W'(QDEPTH) - qcount >= QCNT_W'(grp.n));
	assign byte_stall = valid_s1 && !advance;

	// Input register: refill whenever the held item leaves or none is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			kind_s1 <= kind;
			data_s1 <= data_byte;
		end
	end

	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.kind      (kind_s1),
		.data_byte (data_s1),
		.grp       (grp)
	);

	// A result transfer completes when the queue head is taken.
	assign pop = result_valid && !result_stall;

	jsu_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.grp    (grp),
		.pop    (pop),
		.count  (qcount),
		.head   (head)
	);

	assign result_valid = (qcount != '0);
	assign out_byte     = head.out_byte;
	assign has_byte     = head.has_byte;
	assign status       = head.status;
	assign last         = head.last;

endmodule

FILE: src/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker import jsu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic [2:0] status,
	input logic       last
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte) &&
		$stable(has_byte) && $stable(status) && $stable(last))
		else $error("stalled result changed");

	// A decoded byte is always reported as in progress.
	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && has_byte |-> status == ST_BUSY)
		else $error("decoded byte with final status");

	// A termination result closes its item, carries a real status and no byte.
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_byte |-> last && status != ST_BUSY && out_byte == 8'h00)
		else $error("malformed termination result");

	// Status never goes beyond the bad hex code.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= ST_BAD_HEX)
		else $error("status out of range");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.out_byte     (out_byte),
	.has_byte     (has_byte),
	.status       (status),
	.last         (last)
);

FILE: bench/testbench.sv
// Self-checking testbench for the JSON string unescaper: directed rows, then random strings.
`timescale 1ns / 1ps

module testbench;
	import jsu_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 185;
	localparam int unsigned QUIET_LIMIT  = 1000; // cycles with no transfer before giving up
	localparam int unsigned DRAIN_CYCLES = 10;   // extra wait after the last booked result

	// One row of stimulus. Where typed is set, the expected result is written in
	// the row itself (always a single result with last high); otherwise the
	// decoder model below supplies it.
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       typed;
		logic [7:0] t_byte;
		logic       t_has;
		status_t    t_st;
	} row_t;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic       byte_stall;
	logic       kind         = 1'b0;
	logic [7:0] data_byte    = 8'h00;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [2:0] status;
	logic       last;

	// Decoder model state: escape mode and the hex digits gathered so far.
	mode_t       dec_mode = MODE_PLAIN;
	logic [15:0] dec_hex  = '0;

	result_t fresh[$];    // results of the item just accepted
	result_t awaited[$];  // results still to come out of the block, oldest first
	row_t    plan[$];     // random rows waiting to be sent

	bit          calm = 1'b0; // set during the stretch with no idling on either side
	int unsigned mismatches  = 0;
	int unsigned quiet_cycles = 0;

	// Directed rows: plain bytes at the extremes, a simple escape, a \u escape at
	// the top of the code range in mixed case, and every way a string can end.
	row_t directed_rows [25] = '{
		'{1'b0, "A",       1'b1, "A",    1'b1, ST_BUSY},
		'{1'b0, 8'h00,     1'b1, 8'h00,  1'b1, ST_BUSY},
		'{1'b0, 8'hFF,     1'b1, 8'hFF,  1'b1, ST_BUSY},
		'{1'b0, CH_BSLASH, 1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, CH_N,      1'b1, CH_LF,  1'b1, ST_BUSY},
		'{1'b0, CH_BSLASH, 1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, CH_U,      1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, "F",       1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, "f",       1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, "F",       1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, "f",       1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, CH_BSLASH, 1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, "q",       1'b1, 8'h00,  1'b0, ST_BAD_ESC},
		'{1'b0, CH_LF,     1'b1, 8'h00,  1'b0, ST_UNCLOSED},
		'{1'b0, CH_QUOTE,  1'b1, 8'h00,  1'b0, ST_CLOSED},
		'{1'b1, 8'h5A,     1'b1, 8'h00,  1'b0, ST_UNCLOSED},
		'{1'b0, CH_BSLASH, 1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, CH_LF,     1'b1, 8'h00,  1'b0, ST_BAD_ESC},
		'{1'b0, CH_BSLASH, 1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, CH_U,      1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, "0",       1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, "g",       1'b1, 8'h00,  1'b0, ST_BAD_HEX},
		'{1'b0, CH_BSLASH, 1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b0, CH_U,      1'b0, 8'h00,  1'b0, ST_BUSY},
		'{1'b1, 8'hA5,     1'b1, 8'h00,  1'b0, ST_SHORT_UNI}
	};

	json_string_unescape dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.has_byte     (has_byte),
		.status       (status),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t make_result(input logic [7:0] b, input logic has,
			input status_t st, input logic fin);
		result_t r;
		r.out_byte = b;
		r.has_byte = has;
		r.status   = st;
		r.last     = fin;
		return r;
	endfunction

	// Hex digit value in the low four bits, bit 4 high when the byte is a digit.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] n;
		n = '0;
		if (c >= "0" && c <= "9") begin
			n = {1'b1, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			n = {1'b1, 4'(c - "a" + 8'd10)};
		end else if (c >= "A" && c <= "F") begin
			n = {1'b1, 4'(c - "A" + 8'd10)};
		end
		return n;
	endfunction

	// Any string end: drop back to plain text and report the status alone.
	function automatic void close_string(input status_t st);
		dec_mode = MODE_PLAIN;
		dec_hex  = '0;
		fresh    = {fresh, make_result(8'h00, 1'b0, st, 1'b1)};
	endfunction

	function automatic void emit_byte(input logic [7:0] b, input logic fin);
		fresh = {fresh, make_result(b, 1'b1, ST_BUSY, fin)};
	endfunction

	// Advance the decoder model by one accepted item; its results go to fresh.
	function automatic void step_decoder(input logic k, input logic [7:0] c);
		logic [4:0]  nib;
		logic [15:0] cp;
		nib = nibble_of(c);
		cp  = {dec_hex[11:0], nib[3:0]};
		if (k) begin
			close_string(dec_mode >= MODE_HEX0 ? ST_SHORT_UNI : ST_UNCLOSED);
		end else if (dec_mode == MODE_PLAIN) begin
			if (c == CH_QUOTE) begin
				close_string(ST_CLOSED);
			end else if (c == CH_LF) begin
				close_string(ST_UNCLOSED);
			end else if (c == CH_BSLASH) begin
				dec_mode = MODE_ESC;
			end else begin
				emit_byte(c, 1'b1);
			end
		end else if (dec_mode == MODE_ESC) begin
			dec_mode = MODE_PLAIN;
			case (c)
				CH_QUOTE, CH_BSLASH, CH_SLASH: emit_byte(c, 1'b1);
				CH_B: emit_byte(8'h08, 1'b1);
				CH_F: emit_byte(8'h0C, 1'b1);
				CH_N: emit_byte(8'h0A, 1'b1);
				CH_R: emit_byte(8'h0D, 1'b1);
				CH_T: emit_byte(8'h09, 1'b1);
				CH_U: begin
					dec_mode = MODE_HEX0;
					dec_hex  = '0;
				end
				default: close_string(ST_BAD_ESC);
			endcase
		end else if (!nib[4]) begin
			close_string(ST_BAD_HEX);
		end else if (dec_mode == MODE_HEX3) begin
			// Fourth digit: encode the code point as one to three UTF-8 bytes.
			dec_mode = MODE_PLAIN;
			dec_hex  = '0;
			if (cp <= 16'h007F) begin
				emit_byte(cp[7:0], 1'b1);
			end else if (cp <= 16'h07FF) begin
				emit_byte({3'b110, cp[10:6]}, 1'b0);
				emit_byte({2'b10, cp[5:0]}, 1'b1);
			end else begin
				emit_byte({4'b1110, cp[15:12]}, 1'b0);
				emit_byte({2'b10, cp[11:6]}, 1'b0);
				emit_byte({2'b10, cp[5:0]}, 1'b1);
			end
		end else begin
			dec_hex  = cp;
			dec_mode = mode_t'(dec_mode + 3'd1);
		end
	endfunction

	// Hex digit as text, letters in either case at random.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return "0" + 8'(n);
		end
		return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
	endfunction

	function automatic void plan_byte(input logic k, input logic [7:0] b);
		row_t r;
		r    = '{k, b, 1'b0, 8'h00, 1'b0, ST_BUSY};
		plan = {plan, r};
	endfunction

	// Queue one random piece of a string: mostly well-formed text and escapes,
	// with terminators and broken escapes mixed in.
	function automatic void plan_sequence();
		int unsigned roll;
		int unsigned digits;
		logic [15:0] cp;
		logic [7:0]  b;
		logic [4:0]  nib;
		logic        plain_escape;
		roll = $urandom_range(99);
		if (roll < 45) begin
			// Any byte at all; the odd quote, backslash or newline is welcome.
			plan_byte(1'b0, 8'($urandom_range(255)));
		end else if (roll < 65) begin
			plan_byte(1'b0, CH_BSLASH);
			case ($urandom_range(7))
				0: plan_byte(1'b0, CH_QUOTE);
				1: plan_byte(1'b0, CH_BSLASH);
				2: plan_byte(1'b0, CH_SLASH);
				3: plan_byte(1'b0, CH_B);
				4: plan_byte(1'b0, CH_F);
				5: plan_byte(1'b0, CH_N);
				6: plan_byte(1'b0, CH_R);
				default: plan_byte(1'b0, CH_T);
			endcase
		end else if (roll < 85) begin
			// Full \u escape; spread code points over the one, two and three byte forms.
			case ($urandom_range(2))
				0: cp = 16'($urandom_range(16'h007F));
				1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
				default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
			endcase
			plan_byte(1'b0, CH_BSLASH);
			plan_byte(1'b0, CH_U);
			for (int i = 3; i >= 0; i--) begin
				plan_byte(1'b0, hex_char(cp[i*4 +: 4]));
			end
		end else if (roll < 92) begin
			plan_byte(1'b0, $urandom_range(1) ? CH_QUOTE : CH_LF);
		end else if (roll < 96) begin
			plan_byte(1'b1, 8'($urandom_range(255)));
		end else begin
			plan_byte(1'b0, CH_BSLASH);
			case ($urandom_range(3))
				0: begin
					// Unknown escape letter.
					do begin
						b = 8'($urandom_range(255));
						case (b)
							CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F,
							CH_N, CH_R, CH_T, CH_U: plain_escape = 1'b1;
							default: plain_escape = 1'b0;
						endcase
					end while (plain_escape);
					plan_byte(1'b0, b);
				end
				1: begin
					// \u cut short by end of input.
					plan_byte(1'b0, CH_U);
					digits = $urandom_range(3);
					for (int i = 0; i < digits; i++) begin
						plan_byte(1'b0, hex_char(4'($urandom_range(15))));
					end
					plan_byte(1'b1, 8'($urandom_range(255)));
				end
				2: begin
					// \u broken by a byte that is no hex digit.
					plan_byte(1'b0, CH_U);
					digits = $urandom_range(3);
					for (int i = 0; i < digits; i++) begin
						plan_byte(1'b0, hex_char(4'($urandom_range(15))));
					end
					do begin
						b   = 8'($urandom_range(255));
						nib = nibble_of(b);
					end while (nib[4]);
					plan_byte(1'b0, b);
				end
				default: plan_byte(1'($urandom_range(1)), CH_LF);
			endcase
		end
	endfunction

	// Offer one row on the byte channel from a falling edge, hold it until the
	// transfer, book its results, and return at the next falling edge.
	task automatic send_row(input row_t r);
		while (!calm && $urandom_range(99) < 7) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		kind       <= r.kind;
		data_byte  <= r.data;
		do @(posedge clk); while (byte_stall);
		step_decoder(r.kind, r.data);
		if (r.typed) begin
			fresh.delete();
			awaited = {awaited, make_result(r.t_byte, r.t_has, r.t_st, 1'b1)};
		end else begin
			while (fresh.size() != 0) begin
				awaited = {awaited, fresh.pop_front()};
			end
		end
		@(negedge clk);
	endtask

	// Stall the result channel now and then, except during the calm stretch.
	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 7);
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (result_valid === 1'b1 && !result_stall) begin
			if (awaited.size() == 0) begin
				$error("unexpected result: out_byte %0h has_byte %0b status %0d last %0b",
					out_byte, has_byte, status, last);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
					mismatches++;
				end
				if (has_byte !== want.has_byte) begin
					$error("has_byte: expected %0b, got %0b", want.has_byte, has_byte);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: give up when neither channel has moved for too long.
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid === 1'b1 && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		sent = 0;
		// Hold reset, then release it away from the rising edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_row(directed_rows[i]);
		end

		// Random strings; idling stops for a stretch in the middle of the run.
		while (sent < RANDOM_ITEMS) begin
			plan_sequence();
			while (plan.size() != 0) begin
				calm = (sent >= 100 && sent < 150);
				send_row(plan.pop_front());
				sent++;
			end
		end
		calm = 1'b0;
		byte_valid <= 1'b0;

		// Drain: wait for every booked result, then a few more cycles to catch strays.
		while (awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
